/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("check failed");
`endif

/* rtl/sha512_pkg.sv */
// Package for the SHA-512 engine: round constants, initial hash, helpers.
// Depends on nothing.
package sha512_pkg;
    localparam int WordW = 64;
    localparam int Rounds = 80;
    localparam int RoundW = 7;
    localparam int FillW = 7;
    localparam logic [7:0] PadMark = 8'h80;
    localparam logic [FillW-1:0] LenPos = 7'd112;

    typedef logic [WordW-1:0] word_t;

    localparam word_t InitHash [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam word_t RoundK [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
        64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
        64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
        64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
        64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
        64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
        64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
        64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
        64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
        64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
        64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
        64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
        64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
        64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
        64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
        64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
        64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
        64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
        64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
        64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
        64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    // Start/finish handshake between the sequencer and the round unit.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    function automatic word_t ror(input word_t x, input int n);
        return (x >> n) | (x << (WordW - n));
    endfunction
endpackage

/* rtl/sha512_if.sv */
// Valid/ready channel interfaces for the SHA-512 engine.
// Depends on sha512_pkg.
interface sha512_in_if;
    logic                 valid;
    logic                 ready;
    sha512_pkg::word_t    data_word;
    logic [3:0]           byte_count;
    logic                 last_word;
    modport source (output valid, data_word, byte_count, last_word, input ready);
    modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sha512_out_if;
    logic                 valid;
    logic                 ready;
    sha512_pkg::word_t    digest_word;
    logic [2:0]           word_index;
    logic                 digest_done;
    modport source (output valid, digest_word, word_index, digest_done, input ready);
    modport sink (input valid, digest_word, word_index, digest_done, output ready);
endinterface

/* rtl/sha512_core.sv */
// Round unit: one SHA-512 round per cycle over a 16-word schedule window.
// Depends on sha512_pkg.
module sha512_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sha512_pkg::word_t blk [16],
    input  sha512_pkg::word_t hin [8],
    output sha512_pkg::word_t hout [8],
    output logic              busy,
    output logic              done
);
    sha512_pkg::word_t w_reg [16];
    sha512_pkg::word_t v_reg [8];
    sha512_pkg::word_t h_reg [8];
    logic [sha512_pkg::RoundW-1:0] round_reg;
    logic busy_reg, done_reg;

    sha512_pkg::word_t wt, s0, s1, b1, ch, t1, b0, mj;

    // Round logic; w_reg[0] is the current schedule word.
    always_comb
    begin
        wt = w_reg[0];
        s0 = sha512_pkg::ror(w_reg[1], 1) ^ sha512_pkg::ror(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1 = sha512_pkg::ror(w_reg[14], 19) ^ sha512_pkg::ror(w_reg[14], 61)
           ^ (w_reg[14] >> 6);
        b1 = sha512_pkg::ror(v_reg[4], 14) ^ sha512_pkg::ror(v_reg[4], 18)
           ^ sha512_pkg::ror(v_reg[4], 41);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + b1 + ch + sha512_pkg::RoundK[round_reg] + wt;
        b0 = sha512_pkg::ror(v_reg[0], 28) ^ sha512_pkg::ror(v_reg[0], 34)
           ^ sha512_pkg::ror(v_reg[0], 39);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
                for (int i = 0; i < 16; i++) w_reg[i] <= blk[i];
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= hin[i];
                    h_reg[i] <= hin[i];
                end
            end
            else if (busy_reg)
            begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= w_reg[0] + s0 + w_reg[9] + s1;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + b0 + mj;
                if (round_reg == sha512_pkg::RoundW'(sha512_pkg::Rounds - 1))
                begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    round_reg <= '0;
                end
                else
                begin
                    round_reg <= round_reg + 1'b1;
                end
            end
        end
    end

    // Feed-forward add, valid in the cycle done is high.
    always_comb
    begin
        for (int i = 0; i < 8; i++) hout[i] = h_reg[i] + v_reg[i];
    end

    assign busy = busy_reg;
    assign done = done_reg;
endmodule

/* rtl/sha512_hash_engine.sv */
// Channel   Dir  Payload                                Handshake
// in_ch     in   data_word[63:0] byte_count[3:0] last   valid/ready
// out_ch    out  digest_word[63:0] word_index[2:0] done valid/ready
// An item is accepted, its valid bytes are packed one by one and a closing
// step follows; each 128-byte block it fills is compressed. A last item
// then places the pad mark, pads one byte per cycle up to byte 112 (pausing
// while a full block compresses), runs one or two compressions in the round
// unit and offers eight digest items. Ready is low throughout; output
// stalls only hold the current digest item. Reset restores the initial hash.
// Depends on sha512_pkg, sha512_if, sha512_core.
module sha512_hash_engine (
    input logic clk,
    input logic rst_n,
    sha512_in_if.sink    in_ch,
    sha512_out_if.source out_ch
);
    typedef enum logic [2:0] {
        S_IDLE, S_PACK, S_COMP, S_WAIT, S_PAD, S_OUT
    } state_t;

    state_t state_reg;
    sha512_pkg::word_t blk_reg [16];
    sha512_pkg::word_t hash_reg [8];
    sha512_pkg::word_t hout [8];
    sha512_pkg::word_t data_reg;
    sha512_pkg::word_t msg_reg;
    logic [3:0] cnt_reg;
    logic [3:0] bi_reg;
    logic last_reg;
    logic fin_reg;
    logic mark_reg;
    logic [sha512_pkg::FillW-1:0] fill_reg;
    logic [2:0] oi_reg;
    sha512_pkg::core_ctl_t ctl;

    logic [7:0] byte_in;
    logic [3:0] widx;
    logic [5:0] sh;

    sha512_core u_core (
        .clk(clk), .rst_n(rst_n), .start(ctl.start), .blk(blk_reg),
        .hin(hash_reg), .hout(hout), .busy(ctl.busy), .done(ctl.done)
    );

    assign ctl.start = (state_reg == S_COMP);
    assign byte_in = data_reg[63:56];
    assign widx = fill_reg[6:3];
    assign sh = 6'(56 - 8 * fill_reg[2:0]);

    // Sequencer: byte packing, padding, compression and digest output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            msg_reg   <= '0;
            oi_reg    <= '0;
            fin_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            last_reg  <= 1'b0;
            bi_reg    <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= sha512_pkg::InitHash[i];
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        data_reg <= in_ch.data_word;
                        cnt_reg  <= (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
                        msg_reg  <= msg_reg + 64'((in_ch.byte_count > 4'd8)
                                                  ? 4'd8 : in_ch.byte_count);
                        last_reg <= in_ch.last_word;
                        mark_reg <= 1'b0;
                        bi_reg   <= '0;
                        state_reg <= S_PACK;
                    end
                end
                S_PACK:
                begin
                    if (bi_reg == cnt_reg)
                    begin
                        state_reg <= last_reg ? S_PAD : S_IDLE;
                        fin_reg   <= 1'b0;
                        if (last_reg)
                        begin
                            blk_reg[widx] <= (blk_reg[widx] & ~(64'hFF << sh))
                                           | (64'(sha512_pkg::PadMark) << sh);
                            mark_reg <= 1'b1;
                            fill_reg <= fill_reg + 1'b1;
                            if (fill_reg == 7'd127) state_reg <= S_COMP;
                        end
                    end
                    else
                    begin
                        blk_reg[widx] <= (blk_reg[widx] & ~(64'hFF << sh))
                                       | (64'(byte_in) << sh);
                        data_reg <= data_reg << 8;
                        bi_reg   <= bi_reg + 1'b1;
                        fill_reg <= fill_reg + 1'b1;
                        if (fill_reg == 7'd127) state_reg <= S_COMP;
                    end
                end
                S_COMP:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (ctl.done)
                    begin
                        for (int i = 0; i < 8; i++) hash_reg[i] <= hout[i];
                        if (fin_reg)
                        begin
                            oi_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else if (bi_reg != cnt_reg)
                        begin
                            state_reg <= S_PACK;
                        end
                        else if (mark_reg)
                        begin
                            // pad mark already placed: keep zero filling
                            state_reg <= S_PAD;
                        end
                        else
                        begin
                            // last data byte filled the block: pad mark still due for a last item
                            state_reg <= last_reg ? S_PACK : S_IDLE;
                        end
                    end
                end
                S_PAD:
                begin
                    if (fill_reg == sha512_pkg::LenPos)
                    begin
                        blk_reg[14] <= '0;
                        blk_reg[15] <= msg_reg << 3;
                        fill_reg <= '0;
                        fin_reg  <= 1'b1;
                        state_reg <= S_COMP;
                    end
                    else
                    begin
                        blk_reg[widx] <= blk_reg[widx] & ~(64'hFF << sh);
                        fill_reg <= fill_reg + 1'b1;
                        if (fill_reg == 7'd127) state_reg <= S_COMP;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        oi_reg <= oi_reg + 1'b1;
                        if (oi_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= sha512_pkg::InitHash[i];
                            msg_reg   <= '0;
                            fin_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.digest_word = hash_reg[oi_reg];
    assign out_ch.word_index  = oi_reg;
    assign out_ch.digest_done = (oi_reg == 3'd7);
endmodule

/* rtl/sha512_checker.sv */
// Port-level checks for the SHA-512 engine, bound to the top level.
// Depends on assert_macros.svh and on sha512_hash_engine as the bind target.
`include "assert_macros.svh"
module sha512_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [2:0] word_index,
    input logic digest_done
);
    // never ready for input while a digest is offered
    `CHK_IMPL(a_excl, clk, rst_n, out_valid, !in_ready)
    // done flag marks word seven only
    `CHK_IMPL(a_done, clk, rst_n, out_valid, digest_done == (word_index == 3'd7))
    // accepted word advances the index
    `CHK_NEXT(a_adv, clk, rst_n, out_valid && out_ready && !digest_done,
              out_valid && word_index == $past(word_index) + 3'd1)
    // an accepted input drops ready
    `CHK_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind sha512_hash_engine sha512_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .word_index(out_ch.word_index), .digest_done(out_ch.digest_done)
);
